// ===== hw/rtl/fdss_pkg.sv =====
`default_nettype none

package fdss_pkg;

	localparam int unsigned IDX_W       = 3;
	localparam int unsigned PLACE_COUNT = 8;
	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned ENABLE_W    = 4;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned SEG_W       = 8;
	localparam int unsigned MUL_W       = 17;
	localparam int unsigned SHIFT_W     = 5;
	localparam int unsigned PROD_W      = VALUE_W + MUL_W;
	localparam int unsigned QUOT10_W    = 13;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	localparam logic [31:0] PLACE_WEIGHT [PLACE_COUNT] = '{
		32'd1, 32'd10, 32'd100, 32'd1000,
		32'd10000, 32'd100000, 32'd1000000, 32'd10000000
	};

	// Reciprocal multipliers: (x * MUL) >> SHIFT equals x / 10^k for every 16-bit x.
	// Places above the ten-thousands always hold zero for a 16-bit value.
	localparam logic [MUL_W-1:0] PLACE_MUL [PLACE_COUNT] = '{
		17'd65536, 17'd104858, 17'd83887, 17'd67109,
		17'd107375, 17'd0, 17'd0, 17'd0
	};

	localparam logic [SHIFT_W-1:0] PLACE_SHIFT [PLACE_COUNT] = '{
		5'd16, 5'd20, 5'd23, 5'd26, 5'd30, 5'd16, 5'd16, 5'd16
	};

	localparam logic [MUL_W-1:0] TENTH_MUL   = 17'd104858;
	localparam int unsigned      TENTH_SHIFT = 20;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [IDX_W-1:0]    place;
		logic [ENABLE_W-1:0] enable;
	} entry_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] pattern;
		case (digit)
			4'd0: pattern = 8'hC0;
			4'd1: pattern = 8'hF9;
			4'd2: pattern = 8'hA4;
			4'd3: pattern = 8'hB0;
			4'd4: pattern = 8'h99;
			4'd5: pattern = 8'h92;
			4'd6: pattern = 8'h82;
			4'd7: pattern = 8'hF8;
			4'd8: pattern = 8'h80;
			4'd9: pattern = 8'h90;
			default: pattern = 8'hFF;
		endcase
		return pattern;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_digit_seven_segment_scanner_top.sv =====
`default_nettype none

// Multiplexed seven-segment display scanner. Each item is one scan tick carrying the
// number to show; values beyond the largest that DIGIT_COUNT decimal digits can hold
// are shown as all nines, and leading zeros are displayed. Every item yields one item
// holding the active-low segment pattern (point always off), the active-low one-cold
// digit enable and the digit itself, for the current scan position, which then steps
// from the most significant digit to the least and wraps. One item is accepted per
// clock cycle unless the queue is full; its result passes through a two-entry queue
// and a three-stage digit pipeline (reciprocal multiply, remainder by ten, pattern
// lookup) that holds on out_stall. Enable bits exist only for the four lowest places.
module four_digit_seven_segment_scanner_top #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [fdss_pkg::VALUE_W-1:0]    show_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [fdss_pkg::SEG_W-1:0]           segments,
	output logic [fdss_pkg::ENABLE_W-1:0]        digit_enable,
	output logic [fdss_pkg::DIGIT_W-1:0]         digit_code
);

	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_empty;
	fdss_pkg::entry_t  push_entry;
	fdss_pkg::entry_t  pop_entry;

	fdss_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.show_value (show_value),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fdss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	fdss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.digit_enable (digit_enable),
		.digit_code   (digit_code)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_front.sv =====
`default_nettype none

module fdss_front #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [fdss_pkg::VALUE_W-1:0]  show_value,
	input  wire logic                          queue_full,
	output logic                               push,
	output fdss_pkg::entry_t                   push_entry
);

	localparam int unsigned POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);
	localparam logic [31:0] LIMIT =
		fdss_pkg::PLACE_WEIGHT[DIGIT_COUNT-1] * 32'd10 - 32'd1;

	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              place;
	logic [fdss_pkg::IDX_W-1:0]    idx;
	logic [fdss_pkg::VALUE_W-1:0]  clamped;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		place   = LAST_POS - pos_q;
		idx     = fdss_pkg::IDX_W'(place);
		clamped = ({16'd0, show_value} > LIMIT) ? fdss_pkg::VALUE_W'(LIMIT) : show_value;
		push_entry.value = clamped;
		push_entry.place = idx;
		if (idx < 3'd4) begin
			push_entry.enable = ~(4'b0001 << idx[1:0]);
		end else begin
			push_entry.enable = 4'hF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (pos_q == LAST_POS) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_queue.sv =====
`default_nettype none

module fdss_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire fdss_pkg::entry_t push_entry,
	input  wire logic             pop,
	output fdss_pkg::entry_t      pop_entry,
	output logic                  full,
	output logic                  empty
);

	fdss_pkg::entry_t                 slots_q [fdss_pkg::QUEUE_DEPTH];
	logic [fdss_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [fdss_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [fdss_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == fdss_pkg::QCNT_W'(fdss_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_back.sv =====
`default_nettype none

module fdss_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           queue_empty,
	input  wire fdss_pkg::entry_t               pop_entry,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [fdss_pkg::SEG_W-1:0]          segments,
	output logic [fdss_pkg::ENABLE_W-1:0]       digit_enable,
	output logic [fdss_pkg::DIGIT_W-1:0]        digit_code
);

	logic                              valid_s1;
	logic                              valid_s2;
	logic                              valid_s3;
	logic                              ready_s1;
	logic                              ready_s2;
	logic                              ready_s3;

	logic [fdss_pkg::PROD_W-1:0]       prod_s1;
	logic [fdss_pkg::IDX_W-1:0]        place_s1;
	logic [fdss_pkg::ENABLE_W-1:0]     enable_s1;

	logic [fdss_pkg::VALUE_W-1:0]      quot_s2;
	logic [fdss_pkg::QUOT10_W-1:0]     tenth_s2;
	logic [fdss_pkg::ENABLE_W-1:0]     enable_s2;

	logic [fdss_pkg::SEG_W-1:0]        segments_s3;
	logic [fdss_pkg::ENABLE_W-1:0]     enable_s3;
	logic [fdss_pkg::DIGIT_W-1:0]      digit_s3;

	logic [fdss_pkg::PROD_W-1:0]       prod_in;
	logic [fdss_pkg::PROD_W-1:0]       shifted;
	logic [fdss_pkg::VALUE_W-1:0]      quot;
	logic [fdss_pkg::PROD_W-1:0]       tenth_prod;
	logic [fdss_pkg::VALUE_W-1:0]      tens;
	logic [fdss_pkg::VALUE_W-1:0]      rem;
	logic [fdss_pkg::DIGIT_W-1:0]      digit;

	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop      = !queue_empty && ready_s1;

	assign out_valid    = valid_s3;
	assign segments     = segments_s3;
	assign digit_enable = enable_s3;
	assign digit_code   = digit_s3;

	always_comb begin
		prod_in    = fdss_pkg::PROD_W'(pop_entry.value) *
			fdss_pkg::PROD_W'(fdss_pkg::PLACE_MUL[pop_entry.place]);
		shifted    = prod_s1 >> fdss_pkg::PLACE_SHIFT[place_s1];
		quot       = shifted[fdss_pkg::VALUE_W-1:0];
		tenth_prod = fdss_pkg::PROD_W'(quot) * fdss_pkg::PROD_W'(fdss_pkg::TENTH_MUL);
		tens       = fdss_pkg::VALUE_W'({tenth_s2, 3'b000}) +
			fdss_pkg::VALUE_W'({tenth_s2, 1'b0});
		rem        = quot_s2 - tens;
		digit      = rem[fdss_pkg::DIGIT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1   <= prod_in;
			place_s1  <= pop_entry.place;
			enable_s1 <= pop_entry.enable;
		end
		if (valid_s1 && ready_s2) begin
			quot_s2   <= quot;
			tenth_s2  <= tenth_prod[fdss_pkg::TENTH_SHIFT +: fdss_pkg::QUOT10_W];
			enable_s2 <= enable_s1;
		end
		if (valid_s2 && ready_s3) begin
			segments_s3 <= fdss_pkg::seg_pattern(digit);
			digit_s3    <= digit;
			enable_s3   <= enable_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pop;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

endmodule

`default_nettype wire
